[src/btvg_pkg.sv]
// ----------------------------------------------------------------------------
// btvg_pkg: shared types and constants of the turtle vertex generator
// Request and result formats, operation codes, queue and stack sizes.
// ----------------------------------------------------------------------------
package btvg_pkg;

  localparam int STACK_DEPTH   = 64;
  localparam int HEADING_STEPS = 16;
  localparam int HEAD_W        = $clog2(HEADING_STEPS);
  localparam int STACK_CNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int STACK_ADDR_W  = $clog2(STACK_DEPTH);

  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam int COORD_W       = 32;
  localparam int STEP_W        = 16;
  localparam int SYM_W         = 8;
  localparam int TRIG_FRAC     = 14;
  localparam int COS_C1        = 15137;
  localparam int COS_C2        = 11585;
  localparam int COS_C3        = 6270;

  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 32;

  localparam logic [1:0] REG_START_X       = 2'd0;
  localparam logic [1:0] REG_START_Y       = 2'd1;
  localparam logic [1:0] REG_START_HEADING = 2'd2;
  localparam logic [1:0] REG_STEP_LENGTH   = 2'd3;

  localparam logic [HEAD_W-1:0] START_HEADING_RST = HEAD_W'(12);
  localparam logic [STEP_W-1:0] STEP_LENGTH_RST   = STEP_W'(2560);

  localparam logic [SYM_W-1:0] SYM_FORWARD = 8'h46;
  localparam logic [SYM_W-1:0] SYM_PUSH    = 8'h5B;
  localparam logic [SYM_W-1:0] SYM_POP     = 8'h5D;
  localparam logic [SYM_W-1:0] SYM_CW      = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_CCW     = 8'h2D;

  typedef enum logic [2:0] {
    OP_RESTART,
    OP_FORWARD,
    OP_PUSH,
    OP_POP,
    OP_TURN_CW,
    OP_TURN_CCW
  } op_t;

  typedef enum logic [1:0] {
    KIND_LINE_TO   = 2'd0,
    KIND_MOVE_TO   = 2'd1,
    KIND_OVERFLOW  = 2'd2,
    KIND_UNDERFLOW = 2'd3
  } kind_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             restart;
  } in_item_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic [HEAD_W-1:0]         start_heading;
    logic [STEP_W-1:0]         step_length;
  } cfg_t;

  typedef struct packed {
    logic push;
    op_t  op;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage

[src/btvg_front.sv]
// ----------------------------------------------------------------------------
// btvg_front: request decoder
// Accepts symbol requests and turns each known one into a turtle operation.
// ----------------------------------------------------------------------------
module btvg_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  btvg_pkg::in_item_t in_data,
  input  logic              q_full,
  output btvg_pkg::q_wr_t   q_wr
);
  import btvg_pkg::*;

  logic known;
  op_t  op;

  always_comb begin
    known = 1'b1;
    op    = OP_RESTART;
    if (!in_data.restart) begin
      unique case (in_data.symbol)
        SYM_FORWARD: op = OP_FORWARD;
        SYM_PUSH:    op = OP_PUSH;
        SYM_POP:     op = OP_POP;
        SYM_CW:      op = OP_TURN_CW;
        SYM_CCW:     op = OP_TURN_CCW;
        default:     known = 1'b0;
      endcase
    end
  end

  assign in_stall  = q_full;
  assign q_wr.push = in_valid && !q_full && known;
  assign q_wr.op   = op;

endmodule

[src/btvg_queue.sv]
// ----------------------------------------------------------------------------
// btvg_queue: operation queue
// A short first-in first-out buffer between the decoder and the turtle.
// ----------------------------------------------------------------------------
module btvg_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  btvg_pkg::q_wr_t   q_wr,
  output logic              q_full,
  output btvg_pkg::q_head_t q_head,
  input  logic              q_pop
);
  import btvg_pkg::*;

  op_t                    entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = q_wr.push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    case ({q_wr.push, q_pop})
      2'b10:   cnt_nxt = cnt_r + QUEUE_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QUEUE_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      entry_r[wr_ptr_r] <= q_wr.op;
    end
  end

  assign q_full       = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_head.valid = (cnt_r != '0);
  assign q_head.op    = entry_r[rd_ptr_r];

endmodule

[src/btvg_back.sv]
// ----------------------------------------------------------------------------
// btvg_back: turtle execution unit
// Holds position, heading and the save stack, and drives the result register.
// ----------------------------------------------------------------------------
module btvg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  btvg_pkg::cfg_t      cfg,
  input  btvg_pkg::q_head_t   q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output btvg_pkg::out_item_t out_data
);
  import btvg_pkg::*;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [HEAD_W-1:0]         heading;
  } stack_entry_t;

  typedef enum logic [2:0] {
    MAG_FULL,
    MAG_C1,
    MAG_C2,
    MAG_C3,
    MAG_ZERO
  } mag_t;

  localparam int PROD_W = STEP_W + TRIG_FRAC;
  localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (TRIG_FRAC - 1);

  function automatic mag_t trig_mag(input logic [HEAD_W-1:0] k);
    mag_t m;
    case (k[2:0])
      3'd0:    m = MAG_FULL;
      3'd1:    m = MAG_C1;
      3'd2:    m = MAG_C2;
      3'd3:    m = MAG_C3;
      3'd4:    m = MAG_ZERO;
      3'd5:    m = MAG_C3;
      3'd6:    m = MAG_C2;
      default: m = MAG_C1;
    endcase
    return m;
  endfunction

  function automatic logic trig_neg(input logic [HEAD_W-1:0] k);
    return (k >= HEAD_W'(5)) && (k <= HEAD_W'(11));
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_add(
    input logic signed [COORD_W-1:0] a,
    input logic [STEP_W-1:0]         mag,
    input logic                      neg
  );
    logic signed [COORD_W:0] d;
    logic signed [COORD_W:0] s;
    logic signed [COORD_W-1:0] r;
    d = {{(COORD_W + 1 - STEP_W){1'b0}}, mag};
    if (neg) begin
      d = -d;
    end
    s = {a[COORD_W-1], a} + d;
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

  logic [PROD_W-1:0] p1, p2, p3;
  logic [STEP_W-1:0] d1_r, d2_r, d3_r;

  always_comb begin
    p1 = cfg.step_length * PROD_W'(COS_C1) + ROUND;
    p2 = cfg.step_length * PROD_W'(COS_C2) + ROUND;
    p3 = cfg.step_length * PROD_W'(COS_C3) + ROUND;
  end

  always_ff @(posedge clk) begin
    d1_r <= p1[PROD_W-1:TRIG_FRAC];
    d2_r <= p2[PROD_W-1:TRIG_FRAC];
    d3_r <= p3[PROD_W-1:TRIG_FRAC];
  end

  function automatic logic [STEP_W-1:0] pick(
    input mag_t m, input logic [STEP_W-1:0] full,
    input logic [STEP_W-1:0] c1, input logic [STEP_W-1:0] c2,
    input logic [STEP_W-1:0] c3
  );
    logic [STEP_W-1:0] v;
    case (m)
      MAG_FULL: v = full;
      MAG_C1:   v = c1;
      MAG_C2:   v = c2;
      MAG_C3:   v = c3;
      default:  v = '0;
    endcase
    return v;
  endfunction

  logic signed [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [HEAD_W-1:0]         heading_r, heading_nxt, sin_idx;
  logic [STACK_CNT_W-1:0]    cnt_r, cnt_nxt, top_idx;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;
  logic                      slot_free, adv, stack_we;
  logic [STACK_ADDR_W-1:0]   waddr, raddr;
  stack_entry_t              wdata, rd_r;
  stack_entry_t              stack_mem [STACK_DEPTH];
  logic signed [COORD_W-1:0] fwd_x, fwd_y;

  assign sin_idx   = heading_r + HEAD_W'(12);
  assign fwd_x     = sat_add(x_r, pick(trig_mag(heading_r), cfg.step_length, d1_r, d2_r, d3_r),
                             trig_neg(heading_r));
  assign fwd_y     = sat_add(y_r, pick(trig_mag(sin_idx), cfg.step_length, d1_r, d2_r, d3_r),
                             trig_neg(sin_idx));
  assign slot_free = !out_valid_r || !out_stall;
  assign adv       = q_head.valid &&
                     (slot_free || q_head.op == OP_TURN_CW || q_head.op == OP_TURN_CCW);
  assign q_pop     = adv;
  assign waddr     = cnt_r[STACK_ADDR_W-1:0];
  assign wdata     = '{x: x_r, y: y_r, heading: heading_r};
  assign top_idx   = cnt_nxt - STACK_CNT_W'(1);
  assign raddr     = top_idx[STACK_ADDR_W-1:0];

  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    heading_nxt   = heading_r;
    cnt_nxt       = cnt_r;
    stack_we      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (adv) begin
      unique case (q_head.op)
        OP_RESTART: begin
          x_nxt         = cfg.start_x;
          y_nxt         = cfg.start_y;
          heading_nxt   = cfg.start_heading;
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: KIND_MOVE_TO, vertex_x: cfg.start_x,
                            vertex_y: cfg.start_y};
        end
        OP_FORWARD: begin
          x_nxt         = fwd_x;
          y_nxt         = fwd_y;
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{kind: KIND_LINE_TO, vertex_x: fwd_x, vertex_y: fwd_y};
        end
        OP_PUSH: begin
          if (cnt_r == STACK_CNT_W'(STACK_DEPTH)) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{kind: KIND_OVERFLOW, vertex_x: '0, vertex_y: '0};
          end else begin
            stack_we = 1'b1;
            cnt_nxt  = cnt_r + STACK_CNT_W'(1);
          end
        end
        OP_POP: begin
          out_valid_nxt = 1'b1;
          if (cnt_r == '0) begin
            out_data_nxt = '{kind: KIND_UNDERFLOW, vertex_x: '0, vertex_y: '0};
          end else begin
            cnt_nxt      = cnt_r - STACK_CNT_W'(1);
            x_nxt        = rd_r.x;
            y_nxt        = rd_r.y;
            heading_nxt  = rd_r.heading;
            out_data_nxt = '{kind: KIND_MOVE_TO, vertex_x: rd_r.x, vertex_y: rd_r.y};
          end
        end
        OP_TURN_CW:  heading_nxt = heading_r + HEAD_W'(1);
        OP_TURN_CCW: heading_nxt = heading_r - HEAD_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      y_r         <= '0;
      heading_r   <= START_HEADING_RST;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      heading_r   <= heading_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we && waddr == raddr) begin
      rd_r <= wdata;
    end else begin
      rd_r <= stack_mem[raddr];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= STACK_CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && q_head.op == OP_PUSH && cnt_r == STACK_CNT_W'(STACK_DEPTH)) |=>
    (out_valid_r && out_data_r.kind == KIND_OVERFLOW && cnt_r == STACK_CNT_W'(STACK_DEPTH)))
    else $error("overflow push changed the stack or gave no flag");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && q_head.op == OP_POP && cnt_r != '0) |=>
    (cnt_r == $past(cnt_r) - STACK_CNT_W'(1) && out_data_r.kind == KIND_MOVE_TO))
    else $error("pop did not drop the stack by one");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && q_head.op == OP_RESTART) |=>
    (cnt_r == '0 && out_valid_r && out_data_r.kind == KIND_MOVE_TO))
    else $error("restart did not clear the stack");
`endif

endmodule

[src/bracketed_turtle_vertex_generator.sv]
// ----------------------------------------------------------------------------
// bracketed_turtle_vertex_generator: L-system turtle interpreter
// Turns a stream of bracketed L-system symbols into line-to and move-to
// vertices, with a register port for the start pose and step length.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one symbol request
//   per cycle while in_stall is low. Unknown symbols are dropped by the
//   decoder and give no result. The result channel (out_valid, out_stall,
//   out_data) gives at most one vertex or error flag per request, in
//   request order. A taken request passes through the operation queue to the
//   turtle, whose result register holds each result until it is taken with
//   out_stall low. Throughput is one request per cycle when not stalled, set
//   by the turtle update: one saturating step add per coordinate, with the
//   three scaled step lengths in registers. A four-entry operation queue
//   sits between decoder and turtle; when the receiver stalls, turns keep
//   draining, other operations wait, and in_stall rises once the queue is
//   full. Reset empties the queue and the stack, returns the registers to
//   their defaults and places the turtle at the default start pose. Start
//   pose writes apply at the next restart request, step length writes to later steps.
// ----------------------------------------------------------------------------
module bracketed_turtle_vertex_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  btvg_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output btvg_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [btvg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [btvg_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [btvg_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import btvg_pkg::*;

  logic signed [COORD_W-1:0] start_x_r, start_y_r;
  logic [HEAD_W-1:0]         start_heading_r;
  logic [STEP_W-1:0]         step_length_r;
  logic                      reg_we;
  logic [1:0]                reg_idx;
  cfg_t                      cfg;
  q_wr_t                     q_wr;
  q_head_t                   q_head;
  logic                      q_full, q_pop;

  assign pready  = 1'b1;
  assign reg_we  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r       <= '0;
      start_y_r       <= '0;
      start_heading_r <= START_HEADING_RST;
      step_length_r   <= STEP_LENGTH_RST;
    end else if (reg_we) begin
      unique case (reg_idx)
        REG_START_X:       start_x_r       <= pwdata;
        REG_START_Y:       start_y_r       <= pwdata;
        REG_START_HEADING: start_heading_r <= pwdata[HEAD_W-1:0];
        REG_STEP_LENGTH:   step_length_r   <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_X:       prdata = start_x_r;
      REG_START_Y:       prdata = start_y_r;
      REG_START_HEADING: prdata = {{(CFG_DATA_W-HEAD_W){1'b0}}, start_heading_r};
      REG_STEP_LENGTH:   prdata = {{(CFG_DATA_W-STEP_W){1'b0}}, step_length_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg = '{start_x: start_x_r, start_y: start_y_r,
                 start_heading: start_heading_r, step_length: step_length_r};

  btvg_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  btvg_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  btvg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/tb_bracketed_turtle_vertex_generator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bracketed_turtle_vertex_generator: self-checking bench for the turtle
// Drives L-system symbol requests and register writes, predicts every
// line-to, move-to and stack error vertex, and checks each result in order
// under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_bracketed_turtle_vertex_generator;
  import btvg_pkg::*;

  localparam int RANDOM_ITEMS  = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_LIMIT_NS  = 10_000_000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [CFG_DATA_W-1:0] pwdata    = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  bracketed_turtle_vertex_generator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Predicted turtle state and register copies.
  logic signed [COORD_W-1:0] home_x      = '0;
  logic signed [COORD_W-1:0] home_y      = '0;
  logic [HEAD_W-1:0]         home_facing = START_HEADING_RST;
  logic [STEP_W-1:0]         stride      = STEP_LENGTH_RST;
  logic signed [COORD_W-1:0] pos_x       = '0;
  logic signed [COORD_W-1:0] pos_y       = '0;
  logic [HEAD_W-1:0]         facing      = START_HEADING_RST;
  logic signed [COORD_W-1:0] branch_x [STACK_DEPTH];
  logic signed [COORD_W-1:0] branch_y [STACK_DEPTH];
  logic [HEAD_W-1:0]         branch_facing [STACK_DEPTH];
  int                        branch_depth = 0;

  out_item_t expected_vertices[$];

  bit idle_enable  = 1'b0;
  bit stall_enable = 1'b0;
  int stall_run    = 0;
  int stall_pick;

  int mismatches       = 0;
  int requests_sent    = 0;
  int symbols_dropped  = 0;
  int vertices_checked = 0;
  int overflow_flags   = 0;
  int underflow_flags  = 0;
  int settings_written = 0;

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $time, msg);
  endfunction

  function automatic int heading_cosine(input logic [HEAD_W-1:0] idx);
    int c;
    case (idx)
      4'd0:    c = 1 << TRIG_FRAC;
      4'd1:    c = COS_C1;
      4'd2:    c = COS_C2;
      4'd3:    c = COS_C3;
      4'd4:    c = 0;
      4'd5:    c = -COS_C3;
      4'd6:    c = -COS_C2;
      4'd7:    c = -COS_C1;
      4'd8:    c = -(1 << TRIG_FRAC);
      4'd9:    c = -COS_C1;
      4'd10:   c = -COS_C2;
      4'd11:   c = -COS_C3;
      4'd12:   c = 0;
      4'd13:   c = COS_C3;
      4'd14:   c = COS_C2;
      default: c = COS_C1;
    endcase
    return c;
  endfunction

  // The step is rounded half away from zero, then the sum saturates.
  function automatic logic signed [COORD_W-1:0] step_coord(
    input logic signed [COORD_W-1:0] coord, input int trig);
    longint mag, delta, sum;
    mag = (trig < 0) ? -longint'(trig) : longint'(trig);
    delta = (longint'(stride) * mag + 64'sd8192) >> TRIG_FRAC;
    if (trig < 0) delta = -delta;
    sum = longint'(coord) + delta;
    if (sum > 64'sd2147483647) return {1'b0, {(COORD_W-1){1'b1}}};
    if (sum < -64'sd2147483648) return {1'b1, {(COORD_W-1){1'b0}}};
    return sum[COORD_W-1:0];
  endfunction

  function automatic void advance_turtle(input in_item_t req, output bit emits,
                                         output out_item_t vertex);
    logic [HEAD_W-1:0] sine_idx;
    emits = 1'b0;
    vertex = '0;
    if (req.restart) begin
      pos_x = home_x;
      pos_y = home_y;
      facing = home_facing;
      branch_depth = 0;
      emits = 1'b1;
      vertex.kind = KIND_MOVE_TO;
      vertex.vertex_x = pos_x;
      vertex.vertex_y = pos_y;
    end else begin
      case (req.symbol)
        SYM_FORWARD: begin
          sine_idx = facing + HEAD_W'(12);
          pos_x = step_coord(pos_x, heading_cosine(facing));
          pos_y = step_coord(pos_y, heading_cosine(sine_idx));
          emits = 1'b1;
          vertex.kind = KIND_LINE_TO;
          vertex.vertex_x = pos_x;
          vertex.vertex_y = pos_y;
        end
        SYM_PUSH: begin
          if (branch_depth >= STACK_DEPTH) begin
            emits = 1'b1;
            vertex.kind = KIND_OVERFLOW;
            overflow_flags++;
          end else begin
            branch_x[branch_depth] = pos_x;
            branch_y[branch_depth] = pos_y;
            branch_facing[branch_depth] = facing;
            branch_depth++;
          end
        end
        SYM_POP: begin
          emits = 1'b1;
          if (branch_depth == 0) begin
            vertex.kind = KIND_UNDERFLOW;
            underflow_flags++;
          end else begin
            branch_depth--;
            pos_x = branch_x[branch_depth];
            pos_y = branch_y[branch_depth];
            facing = branch_facing[branch_depth];
            vertex.kind = KIND_MOVE_TO;
            vertex.vertex_x = pos_x;
            vertex.vertex_y = pos_y;
          end
        end
        SYM_CW:  facing = facing + 1'b1;
        SYM_CCW: facing = facing - 1'b1;
        default: symbols_dropped++;
      endcase
    end
  endfunction

  always @(posedge clk) begin
    if (!stall_enable) begin
      stall_run = 0;
      out_stall <= 1'b0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 7);
      end else if (stall_pick < 92) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(9, 29);
      end
    end
  end

  always @(posedge clk) begin : check_vertices
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vertices.size() == 0) begin
        flag_mismatch($sformatf("unexpected vertex kind %0d (%0d, %0d)",
                                out_data.kind, out_data.vertex_x, out_data.vertex_y));
      end else begin
        want = expected_vertices.pop_front();
        if (out_data.kind !== want.kind || out_data.vertex_x !== want.vertex_x ||
            out_data.vertex_y !== want.vertex_y) begin
          flag_mismatch($sformatf("expected kind %0d (%0d, %0d), got kind %0d (%0d, %0d)",
                                  want.kind, want.vertex_x, want.vertex_y,
                                  out_data.kind, out_data.vertex_x, out_data.vertex_y));
        end
        vertices_checked++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [SYM_W-1:0] random_move();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return SYM_CW;
    if (r == 1) return SYM_CCW;
    return SYM_FORWARD;
  endfunction

  task automatic send_request(input logic [SYM_W-1:0] sym, input logic restart_bit);
    in_item_t  req;
    out_item_t vertex;
    bit        emits;
    int        gap;
    req.symbol = sym;
    req.restart = restart_bit;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_turtle(req, emits, vertex);
    if (emits) expected_vertices.push_back(vertex);
    requests_sent++;
  endtask

  task automatic settle_requests();
    in_valid <= 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] want, readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_START_X: begin
        home_x = value;
        want = value;
      end
      REG_START_Y: begin
        home_y = value;
        want = value;
      end
      REG_START_HEADING: begin
        home_facing = value[HEAD_W-1:0];
        want = CFG_DATA_W'(value[HEAD_W-1:0]);
      end
      default: begin
        stride = value[STEP_W-1:0];
        want = CFG_DATA_W'(value[STEP_W-1:0]);
      end
    endcase
    settings_written++;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== want)
      flag_mismatch($sformatf("register %0d read %h, expected %h", index, readback, want));
  endtask

  task automatic write_random_setting();
    logic [CFG_DATA_W-1:0] sx, sy;
    if ($urandom_range(0, 1)) begin
      sx = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      sy = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
    end else begin
      sx = $urandom;
      sy = $urandom;
    end
    write_register(REG_START_X, sx);
    write_register(REG_START_Y, sy);
    write_register(REG_START_HEADING, $urandom);
    if ($urandom_range(0, 1))
      write_register(REG_STEP_LENGTH, {16'($urandom), 16'($urandom_range(0, 4096))});
    else
      write_register(REG_STEP_LENGTH, $urandom);
  endtask

  task automatic test_directed();
    idle_enable = 1'b0;
    stall_enable = 1'b0;
    send_request(SYM_FORWARD, 1'b0);
    send_request(SYM_POP, 1'b0);
    send_request(SYM_PUSH, 1'b0);
    send_request(SYM_CW, 1'b0);
    send_request(SYM_FORWARD, 1'b0);
    send_request(SYM_POP, 1'b0);
    send_request(SYM_CCW, 1'b0);
    send_request(SYM_CCW, 1'b0);
    send_request(SYM_FORWARD, 1'b0);
    send_request(8'h41, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(SYM_FORWARD, 1'b1);
    send_request(SYM_FORWARD, 1'b0);
    send_request(SYM_PUSH, 1'b0);
    send_request(SYM_PUSH, 1'b0);
    send_request(SYM_FORWARD, 1'b0);
    send_request(SYM_POP, 1'b0);
    send_request(SYM_POP, 1'b0);
    send_request(SYM_POP, 1'b0);
    send_request(8'hFF, 1'b1);
    send_request(SYM_PUSH, 1'b1);
    send_request(SYM_POP, 1'b0);
  endtask

  task automatic test_extreme_settings();
    settle_requests();
    idle_enable = 1'b1;
    stall_enable = 1'b1;
    write_register(REG_START_X, 32'h7FFF_FFFF);
    write_register(REG_START_Y, 32'h8000_0000);
    write_register(REG_START_HEADING, 32'hFFFF_FFF0);
    write_register(REG_STEP_LENGTH, 32'h5A5A_FFFF);
    send_request(SYM_FORWARD, 1'b0);
    send_request(8'hA5, 1'b1);
    send_request(SYM_FORWARD, 1'b0);
    repeat (2) send_request(SYM_CW, 1'b0);
    send_request(SYM_FORWARD, 1'b0);
    repeat (4) send_request(SYM_CCW, 1'b0);
    send_request(SYM_FORWARD, 1'b0);
    settle_requests();
    write_register(REG_START_X, 32'h8000_0000);
    write_register(REG_START_Y, 32'h7FFF_FFFF);
    write_register(REG_START_HEADING, 32'h0000_000F);
    write_register(REG_STEP_LENGTH, 32'h0000_0000);
    send_request(SYM_PUSH, 1'b1);
    send_request(SYM_FORWARD, 1'b0);
    settle_requests();
    write_register(REG_STEP_LENGTH, 32'h0000_FFFF);
    repeat (9) send_request(SYM_CCW, 1'b0);
    repeat (2) send_request(SYM_FORWARD, 1'b0);
    settle_requests();
    write_register(REG_START_X, 32'h0000_0000);
    write_register(REG_START_Y, 32'h0000_0000);
    write_register(REG_STEP_LENGTH, 32'hFFFF_0001);
    send_request(SYM_FORWARD, 1'b1);
    repeat (16) begin
      send_request(SYM_CW, 1'b0);
      send_request(SYM_FORWARD, 1'b0);
    end
  endtask

  task automatic test_stack_limits();
    settle_requests();
    idle_enable = 1'b1;
    stall_enable = 1'b1;
    write_register(REG_STEP_LENGTH, 32'h0000_0A00);
    send_request(8'h00, 1'b1);
    repeat (STACK_DEPTH + 3) begin
      repeat ($urandom_range(0, 2)) send_request(random_move(), 1'b0);
      send_request(SYM_PUSH, 1'b0);
    end
    repeat (STACK_DEPTH + 3) begin
      send_request(SYM_POP, 1'b0);
      repeat ($urandom_range(0, 2)) send_request(random_move(), 1'b0);
    end
  endtask

  task automatic run_random_stream(input int budget);
    int done, nest, r, k;
    done = 0;
    while (done < budget) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        nest = 0;
        repeat ($urandom_range(4, 40)) begin
          k = $urandom_range(0, 99);
          if (k < 40) begin
            send_request(SYM_FORWARD, 1'b0);
          end else if (k < 55) begin
            send_request(SYM_CW, 1'b0);
          end else if (k < 70) begin
            send_request(SYM_CCW, 1'b0);
          end else if (k < 85 && nest < 12) begin
            send_request(SYM_PUSH, 1'b0);
            nest++;
          end else if (nest > 0) begin
            send_request(SYM_POP, 1'b0);
            nest--;
          end else begin
            send_request(SYM_FORWARD, 1'b0);
          end
          done++;
        end
        while (nest > 0) begin
          send_request(SYM_POP, 1'b0);
          nest--;
          done++;
        end
      end else if (r < 78) begin
        send_request(8'($urandom), 1'b1);
        done++;
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_request(8'($urandom), 1'b0);
      end else if (r < 95) begin
        repeat ($urandom_range(1, 3)) send_request(SYM_POP, 1'b0);
        done++;
      end else begin
        repeat ($urandom_range(1, 6)) send_request(SYM_PUSH, 1'b0);
        done++;
      end
    end
  endtask

  task automatic test_random_stream();
    for (int phase = 0; phase < 4; phase++) begin
      settle_requests();
      write_random_setting();
      idle_enable = phase[1];
      stall_enable = phase[0];
      if (phase != 2) send_request(8'($urandom), 1'b1);
      run_random_stream(RANDOM_ITEMS / 8);
      settle_requests();
      run_random_stream(RANDOM_ITEMS / 8);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_extreme_settings();
    test_stack_limits();
    test_random_stream();
    settle_requests();
    repeat (20) @(posedge clk);
    $display("Sent %0d symbol requests (%0d dropped) across %0d register writes.",
             requests_sent, symbols_dropped, settings_written);
    $display("Checked %0d vertices, %0d overflow and %0d underflow flags; %0d mismatches.",
             vertices_checked, overflow_flags, underflow_flags, mismatches);
    if (mismatches == 0 && expected_vertices.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d vertices outstanding.", expected_vertices.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

[bracketed_turtle_vertex_generator.f]
src/btvg_pkg.sv
src/btvg_front.sv
src/btvg_queue.sv
src/btvg_back.sv
src/bracketed_turtle_vertex_generator.sv
dv/tb_bracketed_turtle_vertex_generator.sv
